// ===== src/cdq_pkg.sv =====
`default_nettype none

package cdq_pkg;

    localparam int OP_W        = 3;
    localparam int CAP_W       = 5;
    localparam int COUNT_W     = 5;
    localparam int CAP_RESET   = 16;
    localparam int MAX_DEPTH_D = 16;
    localparam int DATA_W_D    = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_QUERY      = 3'd4
    } cdq_op_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic read;
        logic load;
    } cdq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } cdq_stat_t;

endpackage

`default_nettype wire

// ===== src/cdq_ctrl.sv =====
`default_nettype none

module cdq_ctrl
    import cdq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire cdq_stat_t stat,
    output cdq_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_LOAD
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_EXEC;
                        ready_reg <= 1'b0;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    // hold until the output register can take the result
                    if (stat.out_free)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign in_ready    = ready_reg;
    assign cmd.capture = ready_reg & in_valid;
    assign cmd.exec    = (state_reg == S_EXEC);
    assign cmd.read    = (state_reg == S_READ);
    assign cmd.load    = (state_reg == S_LOAD) & stat.out_free;

endmodule

`default_nettype wire

// ===== src/cdq_datapath.sv =====
`default_nettype none

module cdq_datapath
    import cdq_pkg::*;
#(
    parameter int MAX_DEPTH  = MAX_DEPTH_D,
    parameter int DATA_WIDTH = DATA_W_D
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cdq_cmd_t              cmd,
    output cdq_stat_t                  stat,
    input  wire logic [OP_W-1:0]       in_op,
    input  wire logic [DATA_WIDTH-1:0] in_value,
    input  wire logic                  cfg_wen,
    input  wire logic [CAP_W-1:0]      cfg_wdata,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       out_accepted,
    output logic [DATA_WIDTH-1:0]      out_front,
    output logic [DATA_WIDTH-1:0]      out_rear,
    output logic                       out_empty,
    output logic                       out_full,
    output logic [COUNT_W-1:0]         out_count
);

    localparam int CNT_W   = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int EXT_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CAP_RST = (CAP_RESET > MAX_DEPTH) ? MAX_DEPTH : CAP_RESET;

    logic [DATA_WIDTH-1:0] mem_q [MAX_DEPTH];

    logic [OP_W-1:0]       op_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [CNT_W-1:0]      cap_reg;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [IDX_W-1:0]      rear_reg, rear_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic                  acc_reg, acc_next;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] rd_front_reg, rd_rear_reg;

    logic                  out_valid_reg;
    logic                  out_acc_reg;
    logic [DATA_WIDTH-1:0] out_front_reg, out_rear_reg;
    logic                  out_empty_reg, out_full_reg;
    logic [COUNT_W-1:0]    out_count_reg;

    logic [EXT_W-1:0]      cap_in;
    logic [CNT_W-1:0]      cap_eff;
    logic                  is_full, is_empty;
    logic [IDX_W-1:0]      cap_last;
    logic [IDX_W-1:0]      front_dec, rear_inc, front_inc, rear_dec;
    logic                  occ_zero_now;

    // Clamp the written capacity into one to MAX_DEPTH
    always_comb
    begin
        cap_in = EXT_W'(cfg_wdata);
        priority if (cap_in == '0)
            cap_eff = CNT_W'(1);
        else if (cap_in > EXT_W'(MAX_DEPTH))
            cap_eff = CNT_W'(MAX_DEPTH);
        else
            cap_eff = CNT_W'(cap_in);
    end

    assign is_full  = (occ_reg == cap_reg);
    assign is_empty = (occ_reg == '0);
    assign cap_last = IDX_W'(cap_reg - CNT_W'(1));

    assign front_dec = (front_reg == '0) ? cap_last : IDX_W'(front_reg - IDX_W'(1));
    assign rear_dec  = (rear_reg == '0) ? cap_last : IDX_W'(rear_reg - IDX_W'(1));
    assign front_inc = ((CNT_W'(front_reg) + CNT_W'(1)) >= cap_reg) ? '0
                     : IDX_W'(CNT_W'(front_reg) + CNT_W'(1));
    assign rear_inc  = ((CNT_W'(rear_reg) + CNT_W'(1)) >= cap_reg) ? '0
                     : IDX_W'(CNT_W'(rear_reg) + CNT_W'(1));

    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        occ_next   = occ_reg;
        acc_next   = 1'b1;
        wr_en      = 1'b0;
        wr_addr    = '0;
        unique case (op_reg)
            OP_PUSH_FRONT, OP_PUSH_REAR:
            begin
                if (is_full)
                begin
                    acc_next = 1'b0;
                end
                else
                begin
                    wr_en    = 1'b1;
                    occ_next = occ_reg + CNT_W'(1);
                    if (is_empty)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                        wr_addr    = '0;
                    end
                    else if (op_reg == OP_PUSH_FRONT)
                    begin
                        front_next = front_dec;
                        wr_addr    = front_dec;
                    end
                    else
                    begin
                        rear_next = rear_inc;
                        wr_addr   = rear_inc;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_REAR:
            begin
                if (is_empty)
                begin
                    acc_next = 1'b0;
                end
                else
                begin
                    occ_next = occ_reg - CNT_W'(1);
                    if (occ_reg == CNT_W'(1))
                    begin
                        front_next = '0;
                        rear_next  = '0;
                    end
                    else if (op_reg == OP_POP_FRONT)
                    begin
                        front_next = front_inc;
                    end
                    else
                    begin
                        rear_next = rear_dec;
                    end
                end
            end
            default:
            begin
                // query and unused codes change nothing
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
            mem_q[wr_addr] <= value_reg;
        if (cmd.read)
        begin
            rd_front_reg <= mem_q[front_reg];
            rd_rear_reg  <= mem_q[rear_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= in_op;
            value_reg <= in_value;
        end
        if (cmd.exec)
            acc_reg <= acc_next;
        if (cmd.load)
        begin
            out_acc_reg   <= acc_reg;
            out_front_reg <= is_empty ? '1 : rd_front_reg;
            out_rear_reg  <= is_empty ? '1 : rd_rear_reg;
            out_empty_reg <= is_empty;
            out_full_reg  <= is_full;
            out_count_reg <= COUNT_W'(occ_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CNT_W'(CAP_RST);
            front_reg <= '0;
            rear_reg  <= '0;
            occ_reg   <= '0;
        end
        else if (cfg_wen)
        begin
            // a capacity write empties the deque
            cap_reg   <= cap_eff;
            front_reg <= '0;
            rear_reg  <= '0;
            occ_reg   <= '0;
        end
        else if (cmd.exec)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_accepted = out_acc_reg;
    assign out_front    = out_front_reg;
    assign out_rear     = out_rear_reg;
    assign out_empty    = out_empty_reg;
    assign out_full     = out_full_reg;
    assign out_count    = out_count_reg;

    assign occ_zero_now = (occ_reg == '0);

    a_occ_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= cap_reg)
        else $error("occupancy above capacity");

    a_front_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(front_reg) < cap_reg)
        else $error("front index outside capacity");

    a_rear_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(rear_reg) < cap_reg)
        else $error("rear index outside capacity");

    a_empty_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        occ_zero_now |-> (front_reg == '0 && rear_reg == '0))
        else $error("empty deque with nonzero indices");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_front_reg)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== src/circular_deque_unit.sv =====
`default_nettype none

// Double-ended queue held in a ring memory of up to MAX_DEPTH words.
// Input stream s_axis carries one request: an operation code (push front,
// push rear, pop front, pop rear, query) and a data word used by pushes.
// Output stream m_axis returns one result per request: accepted flag, front
// and rear words after the operation (all ones when empty), empty and full
// flags and the entry count. A push when full or a pop when empty is refused
// and leaves the state untouched.
// Each request passes through pointer update and memory write, memory read and
// output load before its result is valid. No new request is taken until the
// current one has been loaded into the output register.
// A result waits in the output register while m_axis_tready is low;
// one further request is taken and processed meanwhile and holds in the load
// step until the register frees.
// Reset empties the deque and sets capacity to 16 (or MAX_DEPTH if smaller).
// cfg_wen writes the capacity (0 reads as 1, values above MAX_DEPTH saturate)
// and empties the deque; write it only while no request is in flight.
module circular_deque_unit
    import cdq_pkg::*;
#(
    parameter int MAX_DEPTH  = MAX_DEPTH_D,
    parameter int DATA_WIDTH = DATA_W_D,
    localparam int S_W = ((OP_W + DATA_WIDTH + 7) / 8) * 8,
    localparam int M_W = ((3 + 2 * DATA_WIDTH + COUNT_W + 7) / 8) * 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // operation, value
    input  wire logic [S_W-1:0]   s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // accepted, front_value, rear_value, is_empty, is_full, entry_count
    output logic [M_W-1:0]        m_axis_tdata,
    input  wire logic             cfg_wen,
    input  wire logic [CAP_W-1:0] cfg_wdata
);

    cdq_cmd_t              cmd;
    cdq_stat_t             stat;
    logic                  accepted;
    logic [DATA_WIDTH-1:0] front_value;
    logic [DATA_WIDTH-1:0] rear_value;
    logic                  is_empty;
    logic                  is_full;
    logic [COUNT_W-1:0]    entry_count;

    cdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cdq_datapath #(
        .MAX_DEPTH  (MAX_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_op        (s_axis_tdata[OP_W-1:0]),
        .in_value     (s_axis_tdata[OP_W +: DATA_WIDTH]),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_accepted (accepted),
        .out_front    (front_value),
        .out_rear     (rear_value),
        .out_empty    (is_empty),
        .out_full     (is_full),
        .out_count    (entry_count)
    );

    assign m_axis_tdata = M_W'({entry_count, is_full, is_empty, rear_value,
                                front_value, accepted});

endmodule

`default_nettype wire

// ===== verif/tb_circular_deque_unit.sv =====
`timescale 1ns / 1ps

module tb_circular_deque_unit;
    import cdq_pkg::*;

    localparam int S_W         = ((OP_W + DATA_W_D + 7) / 8) * 8;
    localparam int M_W         = ((3 + 2 * DATA_W_D + COUNT_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RUN_LEN     = 90;

    // codes 5 to 7 are not assigned; the block treats them as a query
    localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [DATA_W_D-1:0] value;
    } deque_request_t;

    typedef struct packed {
        logic                accepted;
        logic [DATA_W_D-1:0] front_value;
        logic [DATA_W_D-1:0] rear_value;
        logic                is_empty;
        logic                is_full;
        logic [COUNT_W-1:0]  entry_count;
    } deque_status_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [S_W-1:0]   s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [M_W-1:0]   m_axis_tdata;
    logic             cfg_wen       = 1'b0;
    logic [CAP_W-1:0] cfg_wdata     = '0;

    // shadow deque
    logic [DATA_W_D-1:0] ring_words [MAX_DEPTH_D];
    int unsigned         head_ptr;
    int unsigned         tail_ptr;
    int unsigned         fill_level;
    logic [CAP_W-1:0]    cap_setting;

    deque_request_t pending_requests [$];
    deque_status_t  expected_status [$];
    deque_request_t cur_req;
    deque_status_t  want;
    deque_status_t  got;

    bit steady;
    int send_gap;
    int stall_left;
    int cycle_count;
    int error_count;
    int requests_sent;
    int results_checked;
    int refused_count;
    int reserved_count;
    int cap_writes;

    circular_deque_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // operation, value
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // accepted, front_value, rear_value, is_empty, is_full, entry_count
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // apply one operation to the shadow deque and return the status it reports
    function automatic deque_status_t deque_apply(logic [OP_W-1:0] op,
                                                  logic [DATA_W_D-1:0] val);
        deque_status_t r;
        int unsigned   cap;
        int unsigned   slot;
        logic          ok;
        cap = cap_setting;
        if (cap == 0)
            cap = 1;
        if (cap > MAX_DEPTH_D)
            cap = MAX_DEPTH_D;
        ok = 1'b1;
        if (head_ptr >= cap)
            head_ptr = 0;
        if (tail_ptr >= cap)
            tail_ptr = 0;
        if (fill_level > cap)
            fill_level = cap;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR:
            begin
                if (fill_level >= cap)
                    ok = 1'b0;
                else
                begin
                    if (fill_level == 0)
                    begin
                        head_ptr = 0;
                        tail_ptr = 0;
                        slot     = 0;
                    end
                    else if (op == OP_PUSH_FRONT)
                    begin
                        head_ptr = (head_ptr == 0) ? cap - 1 : head_ptr - 1;
                        slot     = head_ptr;
                    end
                    else
                    begin
                        tail_ptr = (tail_ptr + 1 >= cap) ? 0 : tail_ptr + 1;
                        slot     = tail_ptr;
                    end
                    ring_words[slot] = val;
                    fill_level++;
                end
            end
            OP_POP_FRONT, OP_POP_REAR:
            begin
                if (fill_level == 0)
                    ok = 1'b0;
                else
                begin
                    if (fill_level == 1)
                    begin
                        head_ptr = 0;
                        tail_ptr = 0;
                    end
                    else if (op == OP_POP_FRONT)
                        head_ptr = (head_ptr + 1 >= cap) ? 0 : head_ptr + 1;
                    else
                        tail_ptr = (tail_ptr == 0) ? cap - 1 : tail_ptr - 1;
                    fill_level--;
                end
            end
            default:
            begin
            end
        endcase
        r.accepted    = ok;
        r.is_empty    = (fill_level == 0);
        r.front_value = r.is_empty ? '1 : ring_words[head_ptr];
        r.rear_value  = r.is_empty ? '1 : ring_words[tail_ptr];
        r.is_full     = (fill_level == cap);
        r.entry_count = fill_level[COUNT_W-1:0];
        return r;
    endfunction

    function automatic void queue_request(logic [OP_W-1:0] op, logic [DATA_W_D-1:0] val);
        deque_request_t req;
        req.op    = op;
        req.value = val;
        pending_requests.push_back(req);
    endfunction

    function automatic logic [DATA_W_D-1:0] pick_value();
        case ($urandom_range(0, 63))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // bursts that lean toward pushes or pops so occupancy sweeps empty to full
    task automatic queue_random_run(int count);
        int burst_left;
        int push_bias;
        int r;
        burst_left = 0;
        push_bias  = 50;
        for (int i = 0; i < count; i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(4, 40);
                push_bias  = $urandom_range(0, 1) ? 85 : 15;
            end
            burst_left--;
            r = $urandom_range(0, 99);
            if (r < 4)
                queue_request(OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST)),
                              pick_value());
            else if (r < 12)
                queue_request(OP_QUERY, pick_value());
            else if ($urandom_range(0, 99) < push_bias)
                queue_request($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR, pick_value());
            else
                queue_request($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR, pick_value());
        end
    endtask

    // hold the sender until every result is back, then let the pipeline drain
    task automatic wait_idle();
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] cap);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_wen     <= 1'b0;
        cap_setting = cap;
        head_ptr    = 0;
        tail_ptr    = 0;
        fill_level  = 0;
        cap_writes++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = deque_apply(cur_req.op, cur_req.value);
                expected_status.push_back(want);
                requests_sent++;
                if (!want.accepted)
                    refused_count++;
                if (cur_req.op >= OP_RESERVED_FIRST)
                    reserved_count++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0 || pending_requests.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    cur_req = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(S_W - OP_W - DATA_W_D){1'b0}}, cur_req.value, cur_req.op};
                    send_gap = gap_len();
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.accepted    = m_axis_tdata[0];
                got.front_value = m_axis_tdata[DATA_W_D:1];
                got.rear_value  = m_axis_tdata[2*DATA_W_D:DATA_W_D+1];
                got.is_empty    = m_axis_tdata[2*DATA_W_D+1];
                got.is_full     = m_axis_tdata[2*DATA_W_D+2];
                got.entry_count = m_axis_tdata[2*DATA_W_D+3+:COUNT_W];
                if (expected_status.size() == 0)
                begin
                    $error("result with no request outstanding: %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    results_checked++;
                    if (got.accepted !== want.accepted)
                    begin
                        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                        error_count++;
                    end
                    if (got.front_value !== want.front_value)
                    begin
                        $error("front_value: expected %h, got %h",
                               want.front_value, got.front_value);
                        error_count++;
                    end
                    if (got.rear_value !== want.rear_value)
                    begin
                        $error("rear_value: expected %h, got %h",
                               want.rear_value, got.rear_value);
                        error_count++;
                    end
                    if (got.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                        error_count++;
                    end
                    if (got.is_full !== want.is_full)
                    begin
                        $error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
                        error_count++;
                    end
                    if (got.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, got.entry_count);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    stall_left = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [CAP_W-1:0] run_caps [8];
        run_caps    = '{5'd31, 5'd1, 5'd16, 5'd5, 5'd17, 5'd2, 5'd16, 5'd9};
        cap_setting = CAP_RESET;
        head_ptr    = 0;
        tail_ptr    = 0;
        fill_level  = 0;
        steady      = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty deque at reset capacity: refused pops, then both ends and both pops
        queue_request(OP_POP_FRONT, 32'h1234_5678);
        queue_request(OP_POP_REAR, '0);
        queue_request(OP_QUERY, '1);
        queue_request(OP_PUSH_REAR, 32'h7FFF_FFFF);
        queue_request(OP_PUSH_FRONT, 32'h8000_0000);
        queue_request(OP_PUSH_REAR, '0);
        queue_request(OP_PUSH_FRONT, '1);
        queue_request(OP_QUERY, '0);
        queue_request(OP_RESERVED_FIRST, '1);
        queue_request(OP_RESERVED_FIRST + 3'd1, 32'hA5A5_5A5A);
        queue_request(OP_RESERVED_LAST, '0);
        queue_request(OP_POP_FRONT, '0);
        queue_request(OP_POP_REAR, '1);
        queue_request(OP_POP_REAR, '0);
        queue_request(OP_POP_FRONT, '0);
        queue_request(OP_POP_FRONT, '0);
        queue_request(OP_PUSH_FRONT, 32'h0000_0001);
        wait_idle();

        // capacity zero acts as one entry; write it while the deque holds data
        set_capacity('0);
        queue_request(OP_POP_REAR, '0);
        queue_request(OP_PUSH_FRONT, 32'hDEAD_BEEF);
        queue_request(OP_PUSH_REAR, 32'h0BAD_F00D);
        queue_request(OP_POP_FRONT, '0);
        queue_request(OP_POP_REAR, '0);
        wait_idle();

        for (int i = 0; i < 8; i++)
        begin
            set_capacity(run_caps[i]);
            steady = (i % 3 == 2);
            queue_random_run(RUN_LEN);
            wait_idle();
        end
        steady = 1'b0;

        $display("%0d requests over %0d capacity writes, %0d results checked",
                 requests_sent, cap_writes, results_checked);
        $display("%0d requests refused, %0d with unassigned op codes",
                 refused_count, reserved_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
